// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the RIOT port/timer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, held off while reset is high.
`define RPTI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, also checked while reset is high.
`define RPTI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPTI_ASSERT(lbl, clk, rst, prop, msg)
`define RPTI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/rpti_pkg.sv =====
// Types, codes and constants of the RIOT port/timer block.
package rpti_pkg;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_PA7   = 2'd3
  } mode_t;

  // register select with A2 = 0
  localparam logic [1:0] REG_PORTA = 2'd0;
  localparam logic [1:0] REG_DDRA  = 2'd1;
  localparam logic [1:0] REG_PORTB = 2'd2;
  localparam logic [1:0] REG_DDRB  = 2'd3;

  // address bits of the offset
  localparam int unsigned OFF_A0 = 0;
  localparam int unsigned OFF_A1 = 1;
  localparam int unsigned OFF_A2 = 2;
  localparam int unsigned OFF_A3 = 3;
  localparam int unsigned OFF_A4 = 4;

  localparam int unsigned TIMER_W = 19;

  localparam logic [TIMER_W-1:0] TIMER_RESET  = 19'd262144;
  localparam logic [TIMER_W-1:0] TIMER_WRAP   = 19'd256;
  localparam logic [1:0]         PRESCALE_RST = 2'd3;   // divide by 1024

  localparam logic [7:0] FLAG_TIMER = 8'h80;
  localparam logic [7:0] FLAG_EDGE  = 8'h40;

  typedef struct packed {
    mode_t      mode;
    logic [4:0] offset;
    logic [7:0] write_data;
    logic [7:0] tick_cycles;
    logic [7:0] pa_pins;
    logic [7:0] pb_pins;
    logic       pa7_pin_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] port_a_drive;
    logic [7:0] port_b_drive;
    logic       irq;
  } out_item_t;

  // prescale code to shift amount: 1, 8, 64, 1024
  function automatic logic [3:0] prescale_shift(input logic [1:0] code);
    logic [3:0] sh;
    case (code)
      2'd0:    sh = 4'd0;
      2'd1:    sh = 4'd3;
      2'd2:    sh = 4'd6;
      default: sh = 4'd10;
    endcase
    return sh;
  endfunction

endpackage

// ===== rtl/rpti_state.sv =====
// Port, timer and edge-detector registers with their per-item update.
`include "assert_macros.svh"
module rpti_state (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  rpti_pkg::in_item_t  item,
  output rpti_pkg::out_item_t result
);

  logic [7:0] porta_latch, porta_latch_next;
  logic [7:0] porta_dir, porta_dir_next;
  logic [7:0] portb_latch, portb_latch_next;
  logic [7:0] portb_dir, portb_dir_next;
  logic [rpti_pkg::TIMER_W-1:0] timer_left, timer_left_next;
  logic [1:0] prescale, prescale_next;
  logic timer_running, timer_running_next;
  logic timer_irq_en, timer_irq_en_next;
  logic timer_flag, timer_flag_next;
  logic edge_last, edge_last_next;
  logic edge_rising, edge_rising_next;
  logic edge_irq_en, edge_irq_en_next;
  logic edge_flag, edge_flag_next;

  logic [3:0]                   vis_shift;
  logic [rpti_pkg::TIMER_W-1:0] vis_full;
  logic [7:0]                   vis_timer;
  logic [rpti_pkg::TIMER_W-1:0] tick_ext;
  logic [rpti_pkg::TIMER_W-1:0] start_base;
  logic [7:0]                   rd;

  // visible timer value, saturated to a byte
  assign vis_shift = timer_running ? rpti_pkg::prescale_shift(prescale) : 4'd0;
  assign vis_full  = timer_left >> vis_shift;
  assign vis_timer = (|vis_full[rpti_pkg::TIMER_W-1:8]) ? 8'hff : vis_full[7:0];
  assign tick_ext  = {{(rpti_pkg::TIMER_W-8){1'b0}}, item.tick_cycles};

  always_comb begin
    porta_latch_next   = porta_latch;
    porta_dir_next     = porta_dir;
    portb_latch_next   = portb_latch;
    portb_dir_next     = portb_dir;
    timer_left_next    = timer_left;
    prescale_next      = prescale;
    timer_running_next = timer_running;
    timer_irq_en_next  = timer_irq_en;
    timer_flag_next    = timer_flag;
    edge_last_next     = edge_last;
    edge_rising_next   = edge_rising;
    edge_irq_en_next   = edge_irq_en;
    edge_flag_next     = edge_flag;
    rd                 = 8'h00;
    start_base         = {{(rpti_pkg::TIMER_W-8){1'b0}}, item.write_data} + 19'd1;
    case (item.mode)
      rpti_pkg::MODE_READ: begin
        if (!item.offset[rpti_pkg::OFF_A2]) begin
          case (item.offset[1:0])
            rpti_pkg::REG_PORTA: rd = (item.pa_pins & ~porta_dir) | (porta_latch & porta_dir);
            rpti_pkg::REG_DDRA:  rd = porta_dir;
            rpti_pkg::REG_PORTB: rd = (item.pb_pins & ~portb_dir) | (portb_latch & portb_dir);
            default:             rd = portb_dir;
          endcase
        end else if (!item.offset[rpti_pkg::OFF_A0]) begin
          rd                = vis_timer;
          timer_flag_next   = 1'b0;
          timer_irq_en_next = item.offset[rpti_pkg::OFF_A3];
          if (!timer_running) begin
            // restart with the value just read
            start_base         = {{(rpti_pkg::TIMER_W-8){1'b0}}, vis_timer} + 19'd1;
            timer_running_next = 1'b1;
            timer_left_next    = start_base << rpti_pkg::prescale_shift(prescale);
          end
        end else begin
          rd = (timer_flag ? rpti_pkg::FLAG_TIMER : 8'h00) |
               (edge_flag ? rpti_pkg::FLAG_EDGE : 8'h00);
          edge_flag_next = 1'b0;
        end
      end
      rpti_pkg::MODE_WRITE: begin
        if (item.offset[rpti_pkg::OFF_A2]) begin
          if (item.offset[rpti_pkg::OFF_A4]) begin
            prescale_next      = item.offset[1:0];
            timer_running_next = 1'b1;
            timer_left_next    = start_base << rpti_pkg::prescale_shift(item.offset[1:0]);
            timer_flag_next    = 1'b0;
            timer_irq_en_next  = item.offset[rpti_pkg::OFF_A3];
          end else begin
            edge_rising_next = item.offset[rpti_pkg::OFF_A0];
            edge_irq_en_next = item.offset[rpti_pkg::OFF_A1];
          end
        end else begin
          case (item.offset[1:0])
            rpti_pkg::REG_PORTA: porta_latch_next = item.write_data;
            rpti_pkg::REG_DDRA:  porta_dir_next   = item.write_data;
            rpti_pkg::REG_PORTB: portb_latch_next = item.write_data;
            default:             portb_dir_next   = item.write_data;
          endcase
        end
      end
      rpti_pkg::MODE_TICK: begin
        if (item.tick_cycles != 8'd0) begin
          if (tick_ext >= timer_left) begin
            if (timer_running) begin
              timer_flag_next    = 1'b1;
              timer_running_next = 1'b0;
            end
            // underflow by less than 256: one wrap brings it back
            timer_left_next = timer_left + rpti_pkg::TIMER_WRAP - tick_ext;
          end else begin
            timer_left_next = timer_left - tick_ext;
          end
        end
      end
      default: begin
        if (item.pa7_pin_level != edge_last) begin
          edge_last_next = item.pa7_pin_level;
          if (item.pa7_pin_level == edge_rising) edge_flag_next = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    result.read_data    = rd;
    result.port_a_drive = (porta_latch_next & porta_dir_next) | ~porta_dir_next;
    result.port_b_drive = (portb_latch_next & portb_dir_next) | ~portb_dir_next;
    result.irq          = (timer_irq_en_next & timer_flag_next) |
                          (edge_irq_en_next & edge_flag_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      porta_latch   <= 8'h00;
      porta_dir     <= 8'h00;
      portb_latch   <= 8'h00;
      portb_dir     <= 8'h00;
      timer_left    <= rpti_pkg::TIMER_RESET;
      prescale      <= rpti_pkg::PRESCALE_RST;
      timer_running <= 1'b1;
      timer_irq_en  <= 1'b0;
      timer_flag    <= 1'b0;
      edge_last     <= 1'b0;
      edge_rising   <= 1'b0;
      edge_irq_en   <= 1'b0;
      edge_flag     <= 1'b0;
    end else if (fire) begin
      porta_latch   <= porta_latch_next;
      porta_dir     <= porta_dir_next;
      portb_latch   <= portb_latch_next;
      portb_dir     <= portb_dir_next;
      timer_left    <= timer_left_next;
      prescale      <= prescale_next;
      timer_running <= timer_running_next;
      timer_irq_en  <= timer_irq_en_next;
      timer_flag    <= timer_flag_next;
      edge_last     <= edge_last_next;
      edge_rising   <= edge_rising_next;
      edge_irq_en   <= edge_irq_en_next;
      edge_flag     <= edge_flag_next;
    end
  end

  // a stopped timer always has its flag up: both clearing paths restart it
  `RPTI_ASSERT(a_stop_has_flag, clk, rst, !timer_running |-> timer_flag,
               "timer stopped without timeout flag")
  // a timer start write leaves the timer running with the flag cleared
  `RPTI_ASSERT(a_start_runs, clk, rst,
               (fire && item.mode == rpti_pkg::MODE_WRITE && item.offset[rpti_pkg::OFF_A2]
                && item.offset[rpti_pkg::OFF_A4]) |=> (timer_running && !timer_flag),
               "timer start write did not start timer")
  // state only moves when an item is processed
  `RPTI_ASSERT(a_hold_idle, clk, rst, !fire |=> ($stable(timer_left) && $stable(edge_flag)),
               "state changed without an item")
  // non-read items give no read data
  `RPTI_ASSERT(a_rd_zero, clk, rst,
               (item.mode != rpti_pkg::MODE_READ) |-> (result.read_data == 8'h00),
               "read data on a non-read item")

endmodule

// ===== rtl/riot_ports_timer_irq_core.sv =====
// Top level of the RIOT port/timer block: input and result registers around the state update.
// RIOT-style I/O and timer block: two 8-bit ports with direction registers, an
// interval timer with a 1/8/64/1024 prescale, and a PA7 edge detector feeding
// one interrupt line. Each item is a bus read, a bus write, a tick of 0..255
// elapsed cycles, or a new PA7 level; each gives exactly one result carrying
// the read byte (zero for non-reads), the driven port values and the IRQ
// level after the item. Reading the timer after timeout restarts it with the
// value read. Throughput is one item per clock while no stalled result blocks
// the output. An item is captured by the input register when accepted, and its
// result is loaded into the result register when the item is processed; a
// stalled output can hold it in the input register. The state update between
// the two registers is combinational. The input register keeps accepting while
// a result waits on a stalled output, up to one item.
// Reset loads 262144 into the timer, running at the 1024 prescale.
`include "assert_macros.svh"
module riot_ports_timer_irq_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rpti_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output rpti_pkg::out_item_t out_item
);

  logic                s1_valid;   // input register holds an item
  rpti_pkg::in_item_t  s1_item;
  logic                advance;    // result register can take a new result
  logic                fire;       // item in the input register is processed
  rpti_pkg::out_item_t result;

  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  rpti_state u_state (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (s1_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) s1_valid <= in_valid;
      if (advance)   out_valid <= s1_valid;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_item <= in_item;
    if (fire)                  out_item <= result;
  end

  // every processed item shows up as a result in the next cycle
  `RPTI_ASSERT(a_fire_to_out, clk, rst, fire |=> out_valid, "processed item lost")
  // stall toward the source only while the input register is full and blocked
  `RPTI_ASSERT(a_stall_cause, clk, rst, in_stall |-> (s1_valid && out_valid && out_stall),
               "input stalled without a blocked result")
  // nothing valid comes out of reset
  `RPTI_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> (!out_valid && !s1_valid),
                      "pipeline not empty after reset")

endmodule

// ===== tb/riot_ports_timer_irq_core_test.sv =====
// Self-checking testbench for the RIOT port/timer/IRQ core with its own result predictor.
`timescale 1ns / 100ps

module riot_ports_timer_irq_core_test;

  // Cycles with no item moving on either side before the run is declared hung.
  localparam int unsigned HANG_LIMIT  = 2000;
  // Cycles to hold after the last result.
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int unsigned RANDOM_ITEMS = 1925;
  // Window (in items) where neither side idles.
  localparam int unsigned BUSY_FROM = 800;
  localparam int unsigned BUSY_TO   = 1100;
  localparam int unsigned IDLE_PCT  = 26;
  localparam int unsigned IN_W      = $bits(rpti_pkg::in_item_t);
  localparam int unsigned TW        = rpti_pkg::TIMER_W;

  // Offset building blocks for the A2 = 1 half of the register map.
  localparam logic [4:0] OFF_TIMER_START = 5'b10100;  // A4 A2, write
  localparam logic [4:0] OFF_EDGE_CFG    = 5'b00100;  // A2, A4 low, write
  localparam logic [4:0] OFF_TIMER_READ  = 5'b00100;  // A2, A0 low, read
  localparam logic [4:0] OFF_FLAG_READ   = 5'b00101;  // A2 A0, read
  localparam logic [4:0] OFF_IRQ_EN      = 5'b01000;  // A3
  localparam logic [4:0] OFF_IGNORED     = 5'b11000;  // A4 A3 on a port access
  localparam logic [1:0] EDGE_RISING     = 2'b01;     // A0
  localparam logic [1:0] EDGE_IRQ        = 2'b10;     // A1

  localparam logic [3:0] SHIFT_BY_CODE [4] = '{4'd0, 4'd3, 4'd6, 4'd10};

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  rpti_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rpti_pkg::out_item_t out_item;

  rpti_pkg::in_item_t  bus_items [$];          // items waiting to be driven
  rpti_pkg::out_item_t riot_results_due [$];   // predicted results, oldest first
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;

  // Predicted core state, starting at its reset values.
  logic [7:0]    pa_latch = '0, pa_dir = '0, pb_latch = '0, pb_dir = '0;
  logic [TW-1:0] tmr_left = rpti_pkg::TIMER_RESET;
  logic [3:0]    tmr_shift = SHIFT_BY_CODE[rpti_pkg::PRESCALE_RST];
  logic          tmr_running = 1'b1, tmr_irq_en = 1'b0, tmr_expired = 1'b0;
  logic          pa7_last = 1'b0, pa7_rise_sel = 1'b0;
  logic          pa7_irq_en = 1'b0, pa7_seen = 1'b0;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  riot_ports_timer_irq_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Load the count from a byte at the current prescale and let it run.
  function automatic void restart_timer(input logic [7:0] start_val);
    tmr_running = 1'b1;
    tmr_left    = TW'((int'(start_val) + 1) << tmr_shift);
  endfunction

  // Apply one item to the predicted state and return the result it gives.
  function automatic rpti_pkg::out_item_t compute_riot_result(input rpti_pkg::in_item_t it);
    rpti_pkg::out_item_t res;
    logic [7:0]          rd;
    int unsigned         shown;
    rd = '0;
    case (it.mode)
      rpti_pkg::MODE_READ: begin
        if (!it.offset[rpti_pkg::OFF_A2]) begin
          case (it.offset[1:0])
            rpti_pkg::REG_PORTA: rd = (it.pa_pins & ~pa_dir) | (pa_latch & pa_dir);
            rpti_pkg::REG_DDRA:  rd = pa_dir;
            rpti_pkg::REG_PORTB: rd = (it.pb_pins & ~pb_dir) | (pb_latch & pb_dir);
            default:             rd = pb_dir;
          endcase
        end else if (!it.offset[rpti_pkg::OFF_A0]) begin
          // Prescale only applies while running; past timeout the raw count shows.
          shown = 32'(tmr_left >> (tmr_running ? tmr_shift : 4'd0));
          rd = (shown > 255) ? 8'hff : 8'(shown);
          tmr_expired = 1'b0;
          tmr_irq_en  = it.offset[rpti_pkg::OFF_A3];
          if (!tmr_running) restart_timer(rd);  // quirk: read after timeout restarts
        end else begin
          rd = (tmr_expired ? rpti_pkg::FLAG_TIMER : 8'h00) |
               (pa7_seen ? rpti_pkg::FLAG_EDGE : 8'h00);
          pa7_seen = 1'b0;
        end
      end
      rpti_pkg::MODE_WRITE: begin
        if (it.offset[rpti_pkg::OFF_A2]) begin
          if (it.offset[rpti_pkg::OFF_A4]) begin
            tmr_shift = SHIFT_BY_CODE[it.offset[1:0]];
            restart_timer(it.write_data);
            tmr_expired = 1'b0;
            tmr_irq_en  = it.offset[rpti_pkg::OFF_A3];
          end else begin
            pa7_rise_sel = it.offset[rpti_pkg::OFF_A0];
            pa7_irq_en   = it.offset[rpti_pkg::OFF_A1];
          end
        end else begin
          case (it.offset[1:0])
            rpti_pkg::REG_PORTA: pa_latch = it.write_data;
            rpti_pkg::REG_DDRA:  pa_dir   = it.write_data;
            rpti_pkg::REG_PORTB: pb_latch = it.write_data;
            default:             pb_dir   = it.write_data;
          endcase
        end
      end
      rpti_pkg::MODE_TICK: begin
        if (it.tick_cycles != 0) begin
          if (TW'(it.tick_cycles) >= tmr_left) begin
            if (tmr_running) begin
              tmr_expired = 1'b1;
              tmr_running = 1'b0;
            end
            // overshoot is under 256, one wrap brings the count positive again
            tmr_left = tmr_left + rpti_pkg::TIMER_WRAP - TW'(it.tick_cycles);
          end else begin
            tmr_left = tmr_left - TW'(it.tick_cycles);
          end
        end
      end
      default: begin
        if (it.pa7_pin_level != pa7_last) begin
          pa7_last = it.pa7_pin_level;
          if (it.pa7_pin_level == pa7_rise_sel) pa7_seen = 1'b1;
        end
      end
    endcase
    res.read_data    = rd;
    res.port_a_drive = (pa_latch & pa_dir) | ~pa_dir;
    res.port_b_drive = (pb_latch & pb_dir) | ~pb_dir;
    res.irq          = (tmr_irq_en & tmr_expired) | (pa7_irq_en & pa7_seen);
    return res;
  endfunction

  // Item of a given kind; arg is the write byte, the tick count or (bit 0) the PA7 level.
  // Fields the kind does not use are left random since the core must ignore them.
  function automatic rpti_pkg::in_item_t make_item(input rpti_pkg::mode_t kind,
                                                   input logic [4:0] off,
                                                   input logic [7:0] arg);
    rpti_pkg::in_item_t it;
    it = rpti_pkg::in_item_t'(IN_W'({$urandom, $urandom}));
    it.mode   = kind;
    it.offset = off;
    case (kind)
      rpti_pkg::MODE_WRITE: it.write_data    = arg;
      rpti_pkg::MODE_TICK:  it.tick_cycles   = arg;
      rpti_pkg::MODE_PA7:   it.pa7_pin_level = arg[0];
      default: ;
    endcase
    return it;
  endfunction

  // Random traffic, biased so the timer actually times out and the edge logic fires.
  function automatic rpti_pkg::in_item_t random_bus_item();
    int unsigned        pick;
    logic [1:0]         code;
    logic [7:0]         arg;
    rpti_pkg::in_item_t it;
    pick = $urandom_range(99);
    if (pick < 30) begin
      it = make_item(rpti_pkg::MODE_READ, 5'($urandom), 8'h00);
    end else if (pick < 40) begin
      it = make_item(rpti_pkg::MODE_WRITE, {2'($urandom), 1'b0, 2'($urandom)},
                     8'($urandom));
    end else if (pick < 50) begin
      // short timer runs mostly: prescale 1 or 8 with small start values
      code = ($urandom_range(99) < 85) ? 2'($urandom_range(1)) : 2'($urandom);
      arg  = ($urandom_range(99) < 80) ? 8'($urandom_range(31)) : 8'($urandom);
      it = make_item(rpti_pkg::MODE_WRITE,
                     OFF_TIMER_START | {1'b0, 1'($urandom), 3'b000} | code, arg);
    end else if (pick < 53) begin
      it = make_item(rpti_pkg::MODE_WRITE,
                     OFF_EDGE_CFG | {1'b0, 1'($urandom), 3'b000} | 2'($urandom),
                     8'($urandom));
    end else if (pick < 56) begin
      it = make_item(rpti_pkg::MODE_WRITE, 5'($urandom), 8'($urandom));
    end else if (pick < 85) begin
      case ($urandom_range(3))
        0:       arg = 8'h00;
        1:       arg = 8'($urandom_range(15));
        default: arg = 8'($urandom);
      endcase
      it = make_item(rpti_pkg::MODE_TICK, 5'($urandom), arg);
    end else begin
      it = make_item(rpti_pkg::MODE_PA7, 5'($urandom), 8'($urandom_range(1)));
    end
    return it;
  endfunction

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Driver: predict each item as it is taken, then present the next one or idle.
  always @(posedge clk) begin : driver
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        riot_results_due.push_back(compute_riot_result(in_item));
        items_sent++;
      end
      // a held (stalled) item must stay put
      if (!in_valid || !in_stall) begin
        if (bus_items.size() != 0 &&
            !((items_sent < BUSY_FROM || items_sent > BUSY_TO) &&
              $urandom_range(99) < IDLE_PCT)) begin
          in_item  <= bus_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result with the oldest prediction, stall at random.
  always @(posedge clk) begin : monitor
    rpti_pkg::out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_fire) begin
        results_seen++;
        if (riot_results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
          mismatches++;
        end else begin
          want = riot_results_due.pop_front();
          check_field("read_data", want.read_data, out_item.read_data);
          check_field("port_a_drive", want.port_a_drive, out_item.port_a_drive);
          check_field("port_b_drive", want.port_b_drive, out_item.port_b_drive);
          check_field("irq", 8'(want.irq), 8'(out_item.irq));
        end
      end
      out_stall <= (results_seen < BUSY_FROM || results_seen > BUSY_TO) &&
                   ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Hang detector: nothing moving on either side for too long.
  always @(posedge clk) begin : watchdog
    if (rst || in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == HANG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    rpti_pkg::in_item_t it;

    // Port registers: reset reads, A3/A4 ignored, pins vs latch by direction.
    it = make_item(rpti_pkg::MODE_READ, {3'b000, rpti_pkg::REG_PORTA}, 8'h00);
    it.pa_pins = 8'hff;
    bus_items.push_back(it);
    bus_items.push_back(make_item(rpti_pkg::MODE_READ, OFF_IGNORED | rpti_pkg::REG_DDRA,
                                  8'h00));
    bus_items.push_back(make_item(rpti_pkg::MODE_WRITE, {3'b000, rpti_pkg::REG_DDRA},
                                  8'hff));
    bus_items.push_back(make_item(rpti_pkg::MODE_WRITE, {3'b000, rpti_pkg::REG_PORTA},
                                  8'ha5));
    bus_items.push_back(make_item(rpti_pkg::MODE_WRITE, {3'b000, rpti_pkg::REG_DDRB},
                                  8'h0f));
    bus_items.push_back(make_item(rpti_pkg::MODE_WRITE, OFF_IGNORED | rpti_pkg::REG_PORTB,
                                  8'h3c));
    it = make_item(rpti_pkg::MODE_READ, {3'b000, rpti_pkg::REG_PORTA}, 8'h00);
    it.pa_pins = 8'h00;
    bus_items.push_back(it);
    it = make_item(rpti_pkg::MODE_READ, {3'b000, rpti_pkg::REG_PORTB}, 8'h00);
    it.pb_pins = 8'hff;
    bus_items.push_back(it);
    bus_items.push_back(make_item(rpti_pkg::MODE_READ, {3'b000, rpti_pkg::REG_DDRB}, 8'h00));

    // Timer: short run to timeout with IRQ, flag read, wrap after expiry,
    // restart-on-read, then the saturated read at the /1024 prescale.
    bus_items.push_back(make_item(rpti_pkg::MODE_WRITE, OFF_TIMER_START | OFF_IRQ_EN, 8'h02));
    bus_items.push_back(make_item(rpti_pkg::MODE_TICK, 5'h00, 8'd3));
    bus_items.push_back(make_item(rpti_pkg::MODE_READ, OFF_FLAG_READ, 8'h00));
    bus_items.push_back(make_item(rpti_pkg::MODE_TICK, 5'h1f, 8'd255));
    bus_items.push_back(make_item(rpti_pkg::MODE_READ, OFF_TIMER_READ | OFF_IRQ_EN, 8'h00));
    bus_items.push_back(make_item(rpti_pkg::MODE_WRITE, OFF_TIMER_START | 5'd3, 8'hff));
    bus_items.push_back(make_item(rpti_pkg::MODE_TICK, 5'h00, 8'd0));
    bus_items.push_back(make_item(rpti_pkg::MODE_READ, OFF_TIMER_READ, 8'h00));

    // PA7 edge detector: rising edge with IRQ, repeated level, flag clear,
    // then falling select.
    bus_items.push_back(make_item(rpti_pkg::MODE_WRITE,
                                  OFF_EDGE_CFG | EDGE_IRQ | EDGE_RISING, 8'h00));
    bus_items.push_back(make_item(rpti_pkg::MODE_PA7, 5'h00, 8'h01));
    bus_items.push_back(make_item(rpti_pkg::MODE_PA7, 5'h00, 8'h01));
    bus_items.push_back(make_item(rpti_pkg::MODE_READ, OFF_FLAG_READ | OFF_IRQ_EN, 8'h00));
    bus_items.push_back(make_item(rpti_pkg::MODE_WRITE, OFF_EDGE_CFG | EDGE_IRQ, 8'h00));
    bus_items.push_back(make_item(rpti_pkg::MODE_PA7, 5'h00, 8'h00));
    bus_items.push_back(make_item(rpti_pkg::MODE_WRITE, {3'b000, rpti_pkg::REG_DDRA},
                                  8'h00));
    bus_items.push_back(make_item(rpti_pkg::MODE_WRITE, {3'b000, rpti_pkg::REG_PORTA},
                                  8'hff));

    for (int i = 0; i < RANDOM_ITEMS; i++) bus_items.push_back(random_bus_item());

    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Wait for every item to be taken and every prediction to be matched.
    while (bus_items.size() != 0 || in_valid || riot_results_due.size() != 0)
      @(posedge clk);
    // catch any stray extra result
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== riot_ports_timer_irq_core.f =====
+incdir+rtl
rtl/rpti_pkg.sv
rtl/rpti_state.sv
rtl/riot_ports_timer_irq_core.sv
tb/riot_ports_timer_irq_core_test.sv
